### sv/tda_pkg.sv
// Shared types, constants and calendar helpers for the time zone date adjuster.
`timescale 1ns / 1ps
`default_nettype none

package tda_pkg;

  // Configuration register indexes
  localparam logic CFG_OFFSET_HOURS = 1'b0;
  localparam logic CFG_EAST_OF_UTC  = 1'b1;
  localparam int   CFG_DATA_W       = 4;

  // Calendar constants
  localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
  localparam logic [3:0]  MAX_OFFSET    = 4'd12;
  localparam logic [13:0] YEAR_TOP      = 14'd9999;
  localparam logic [3:0]  MONTH_JAN     = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;
  localparam logic [4:0]  DAYS_LONG     = 5'd31;
  localparam logic [4:0]  DAYS_SHORT    = 5'd30;
  localparam logic [4:0]  DAYS_FEB      = 5'd28;
  localparam logic [4:0]  DAYS_FEB_LEAP = 5'd29;

  // Divisibility by 25 on a 14-bit year: multiply by the inverse of 25
  // modulo 2^14; the low 14 bits fall at or below 16383/25 exactly for multiples.
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_MAX = 14'd655;

  typedef struct packed {
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } tda_in_t;

  typedef struct packed {
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        applied;
  } tda_out_t;

  // After the hour stage
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        applied;
    logic        east;
    logic        roll;
    logic [13:0] year_prod;
  } tda_s1_t;

  // After the month length stage
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        applied;
    logic        east;
    logic        roll;
    logic        wrap_fwd;
    logic [4:0]  prev_len;
  } tda_s2_t;

  // Length of month m; months outside 1..12 read as long months
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB:                 len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      4'd4, 4'd6, 4'd9, 4'd11:   len = DAYS_SHORT;
      default:                   len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### sv/tda_hour_stage.sv
// First pipeline stage: hour shift, day carry or borrow, and the year product.
`timescale 1ns / 1ps
`default_nettype none

module tda_hour_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire tda_pkg::tda_in_t up_data,
  input  wire logic [3:0]       offset_hours,
  input  wire logic             east_of_utc,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output tda_pkg::tda_s1_t      dn_data
);
  import tda_pkg::*;

  logic    valid_r;
  tda_s1_t data_r;
  tda_s1_t data_nxt;

  logic [5:0]  sum_fwd;
  logic        carry;
  logic        borrow;
  logic        apply;
  logic        month_ok;
  logic [13:0] prod_lo;

  // Hour arithmetic and the per-item decisions
  always_comb begin
    apply    = (offset_hours != 4'd0) && (offset_hours <= MAX_OFFSET);
    month_ok = (up_data.month_in >= MONTH_JAN) && (up_data.month_in <= MONTH_DEC);
    sum_fwd  = {1'b0, up_data.hour_in} + {2'b00, offset_hours};
    carry    = (sum_fwd >= HOURS_PER_DAY);
    borrow   = (up_data.hour_in < {1'b0, offset_hours});
    prod_lo  = up_data.year_in * INV25;

    data_nxt.year      = up_data.year_in;
    data_nxt.month     = up_data.month_in;
    data_nxt.day       = up_data.day_in;
    data_nxt.minute    = up_data.minute_in;
    data_nxt.second    = up_data.second_in;
    data_nxt.applied   = apply;
    data_nxt.east      = east_of_utc;
    data_nxt.year_prod = prod_lo;
    data_nxt.hour      = up_data.hour_in;
    data_nxt.roll      = 1'b0;
    if (apply) begin
      if (east_of_utc) begin
        data_nxt.hour = carry ? 5'(sum_fwd - HOURS_PER_DAY) : sum_fwd[4:0];
        data_nxt.roll = carry && month_ok;
      end else begin
        data_nxt.hour = borrow ? 5'(up_data.hour_in + 5'(HOURS_PER_DAY) - {1'b0, offset_hours})
                               : 5'(up_data.hour_in - {1'b0, offset_hours});
        data_nxt.roll = borrow && month_ok;
      end
    end
  end

  // Advance when the next stage can take the transfer or this one is empty
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### sv/tda_len_stage.sv
// Second pipeline stage: leap year test, month lengths and the day wrap decision.
`timescale 1ns / 1ps
`default_nettype none

module tda_len_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire tda_pkg::tda_s1_t up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output tda_pkg::tda_s2_t      dn_data
);
  import tda_pkg::*;

  logic    valid_r;
  tda_s2_t data_r;
  tda_s2_t data_nxt;

  logic       div25;
  logic       leap;
  logic [4:0] cur_len;
  logic [3:0] prev_month;

  // Gregorian leap test on the full year, then both candidate month lengths
  always_comb begin
    div25      = (up_data.year_prod <= DIV25_MAX);
    leap       = (up_data.year[1:0] == 2'b00) && (!div25 || (up_data.year[3:0] == 4'd0));
    cur_len    = month_days(up_data.month, leap);
    prev_month = up_data.month - 4'd1;

    data_nxt.year     = up_data.year;
    data_nxt.month    = up_data.month;
    data_nxt.day      = up_data.day;
    data_nxt.hour     = up_data.hour;
    data_nxt.minute   = up_data.minute;
    data_nxt.second   = up_data.second;
    data_nxt.applied  = up_data.applied;
    data_nxt.east     = up_data.east;
    data_nxt.roll     = up_data.roll;
    data_nxt.wrap_fwd = (up_data.day >= cur_len);
    data_nxt.prev_len = month_days(prev_month, leap);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### sv/tda_date_stage.sv
// Last pipeline stage: apply the day, month and year roll into the output register.
`timescale 1ns / 1ps
`default_nettype none

module tda_date_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire tda_pkg::tda_s2_t up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output tda_pkg::tda_out_t     dn_data
);
  import tda_pkg::*;

  logic     valid_r;
  tda_out_t data_r;
  tda_out_t data_nxt;

  // Roll the date forward or back by one day where the hour crossed midnight
  always_comb begin
    data_nxt.year_out   = up_data.year;
    data_nxt.month_out  = up_data.month;
    data_nxt.day_out    = up_data.day;
    data_nxt.hour_out   = up_data.hour;
    data_nxt.minute_out = up_data.minute;
    data_nxt.second_out = up_data.second;
    data_nxt.applied    = up_data.applied;
    if (up_data.roll) begin
      if (up_data.east) begin
        if (!up_data.wrap_fwd) begin
          data_nxt.day_out = up_data.day + 5'd1;
        end else begin
          data_nxt.day_out = 5'd1;
          if (up_data.month == MONTH_DEC) begin
            data_nxt.month_out = MONTH_JAN;
            data_nxt.year_out  = (up_data.year >= YEAR_TOP) ? 14'd0 : up_data.year + 14'd1;
          end else begin
            data_nxt.month_out = up_data.month + 4'd1;
          end
        end
      end else begin
        if (up_data.day > 5'd1) begin
          data_nxt.day_out = up_data.day - 5'd1;
        end else if (up_data.month == MONTH_JAN) begin
          data_nxt.month_out = MONTH_DEC;
          data_nxt.day_out   = DAYS_LONG;
          data_nxt.year_out  = (up_data.year == 14'd0) ? YEAR_TOP : up_data.year - 14'd1;
        end else begin
          data_nxt.month_out = up_data.month - 4'd1;
          data_nxt.day_out   = up_data.prev_len;
        end
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### sv/timezone_date_adjust_core.sv
// Top level of the time zone date adjuster: config registers and the three-stage pipeline.
//
//  channel  | ports                          | direction | transfer when
//  ---------+--------------------------------+-----------+---------------------------
//  input    | in_valid, in_stall, in_data    | in        | in_valid && !in_stall
//  result   | out_valid, out_stall, out_data | out       | out_valid && !out_stall
//  config   | cfg_wr_en, cfg_index, cfg_wdata| in        | cfg_wr_en
//
//  One item enters per cycle while in_stall is low; its result is registered through
//  the hour, length and date stages before it is offered on out_valid.
//  The three stages are hour shift, month length and date roll.
//  Synchronous active-low reset empties the pipeline and loads offset 8, east.
//  A stall on the result side holds each full stage; empty stages still fill,
//  so in_stall rises only when every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none

module timezone_date_adjust_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire tda_pkg::tda_in_t             in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output tda_pkg::tda_out_t                 out_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_index,
  input  wire logic [tda_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tda_pkg::*;

  logic [3:0] offset_hours_r;
  logic       east_of_utc_r;

  logic    s1_ready;
  logic    s1_valid;
  tda_s1_t s1_data;
  logic    s2_ready;
  logic    s2_valid;
  tda_s2_t s2_data;
  logic    s3_ready;

  // Decode configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_hours_r <= 4'd8;
      east_of_utc_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OFFSET_HOURS: offset_hours_r <= cfg_wdata[3:0];
        CFG_EAST_OF_UTC:  east_of_utc_r  <= cfg_wdata[0];
        default:          offset_hours_r <= offset_hours_r;
      endcase
    end
  end

  tda_hour_stage u_hour (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_ready     (s1_ready),
    .up_data      (in_data),
    .offset_hours (offset_hours_r),
    .east_of_utc  (east_of_utc_r),
    .dn_valid     (s1_valid),
    .dn_ready     (s2_ready),
    .dn_data      (s1_data)
  );

  tda_len_stage u_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_data  (s2_data)
  );

  tda_date_stage u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_data  (out_data)
  );

  // Stall the input only when the first stage is full and cannot drain
  assign in_stall = !s1_ready;

`ifndef ASSERT_OFF
  // An empty first stage always takes a transfer
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> !in_stall)
    else $error("input stalled with first stage empty");

  // A date roll only happens when the offset is applied
  a_roll_applied: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s1_data.roll) |-> s1_data.applied)
    else $error("date roll without applied offset");

  // A held middle stage keeps its item
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && !s3_ready) |=> (s2_valid && $stable(s2_data)))
    else $error("middle stage lost or changed a held item");
`endif

endmodule

`default_nettype wire
